/* rtl/core/miu_pkg.sv */
`default_nettype none

package miu_pkg;

    // default datapath width and modulus after reset
    localparam int WIDTH_DEF     = 16;
    localparam int MODULUS_RESET = 256;

    // sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } miu_status_t;

endpackage

`default_nettype wire

/* rtl/core/miu_core.sv */
`default_nettype none

module miu_core
    import miu_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] value,
    input  wire logic [WIDTH-1:0] modulus,
    input  wire logic             res_ack,
    output miu_status_t           status,
    output logic      [WIDTH-1:0] res_inverse,
    output logic                  res_has_inverse
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] dividend_reg, dividend_next;
    logic [WIDTH-1:0] divisor_reg, divisor_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] old_t_reg, old_t_next;
    logic [WIDTH-1:0] cur_t_reg, cur_t_next;
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             ok_reg, ok_next;

    logic [WIDTH:0]   m_ext;
    logic [WIDTH:0]   cand;
    logic [WIDTH:0]   cand_diff;
    logic             ge;
    logic [WIDTH-1:0] rem_step;
    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_diff;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_diff;
    logic [WIDTH-1:0] acc_step;
    logic [WIDTH:0]   t_diff;
    logic [WIDTH:0]   t_wrap;
    logic [WIDTH-1:0] new_t;

    // shared restoring divide step: one quotient bit per cycle
    assign m_ext     = {1'b0, modulus};
    assign cand      = {rem_reg, dividend_reg[WIDTH-1]};
    assign cand_diff = cand - {1'b0, divisor_reg};
    assign ge        = (cand >= {1'b0, divisor_reg});
    assign rem_step  = ge ? cand_diff[WIDTH-1:0] : cand[WIDTH-1:0];

    // horner accumulation of quotient times cur_t, mod modulus
    assign dbl      = {acc_reg, 1'b0};
    assign dbl_diff = dbl - m_ext;
    assign dbl_red  = (dbl >= m_ext) ? dbl_diff[WIDTH-1:0] : dbl[WIDTH-1:0];
    assign sum      = {1'b0, dbl_red} + {1'b0, (ge ? cur_t_reg : {WIDTH{1'b0}})};
    assign sum_diff = sum - m_ext;
    assign acc_step = (sum >= m_ext) ? sum_diff[WIDTH-1:0] : sum[WIDTH-1:0];

    // new coefficient: old_t minus product, kept in [0, modulus)
    assign t_diff = {1'b0, old_t_reg} - {1'b0, acc_reg};
    assign t_wrap = t_diff + m_ext;
    assign new_t  = (old_t_reg >= acc_reg) ? t_diff[WIDTH-1:0] : t_wrap[WIDTH-1:0];

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        old_t_next    = old_t_reg;
        cur_t_next    = cur_t_reg;
        inv_next      = inv_reg;
        ok_next       = ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dividend_next = value;
                    divisor_next  = modulus;
                    rem_next      = '0;
                    cnt_next      = CW'(WIDTH - 1);
                    inv_next      = '0;
                    ok_next       = 1'b0;
                    if (modulus < WIDTH'(2))
                        state_next = ST_DONE;
                    else
                        state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                dividend_next = {dividend_reg[WIDTH-2:0], 1'b0};
                rem_next      = rem_step;
                cnt_next      = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    if (rem_step == '0)
                        state_next = ST_DONE;
                    else
                    begin
                        // set up euclid on (modulus, reduced value)
                        dividend_next = modulus;
                        divisor_next  = rem_step;
                        rem_next      = '0;
                        acc_next      = '0;
                        old_t_next    = '0;
                        cur_t_next    = WIDTH'(1);
                        cnt_next      = CW'(WIDTH - 1);
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                dividend_next = {dividend_reg[WIDTH-2:0], 1'b0};
                rem_next      = rem_step;
                acc_next      = acc_step;
                cnt_next      = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                old_t_next    = cur_t_reg;
                cur_t_next    = new_t;
                dividend_next = divisor_reg;
                divisor_next  = rem_reg;
                if (rem_reg == '0)
                begin
                    // gcd is the last nonzero remainder
                    if (divisor_reg == WIDTH'(1))
                    begin
                        inv_next = cur_t_reg;
                        ok_next  = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = CW'(WIDTH - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (res_ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        old_t_reg    <= old_t_next;
        cur_t_reg    <= cur_t_next;
        inv_reg      <= inv_next;
        ok_reg       <= ok_next;
    end

    assign status.busy     = (state_reg != ST_IDLE);
    assign status.done     = (state_reg == ST_DONE);
    assign res_inverse     = inv_reg;
    assign res_has_inverse = ok_reg;

endmodule

`default_nettype wire

/* rtl/core/modular_inverse_unit.sv */
// modular_inverse_unit: multiplicative inverse of a word modulo a configured modulus
//
// channels
//   input word  (in_valid/in_ready, value): number whose inverse is wanted
//   result word (out_valid/out_ready, inverse, has_inverse): inverse, or 0
//     with has_inverse low when value and modulus share a factor
//   config word (cfg_valid/cfg_ready, modulus): cfg_ready is always high; new
//     modulus, which the user writes only while no word is in flight (not enforced)
// sequence: value is first reduced mod modulus, then each euclid step is a
//   divide followed by a coefficient update, and the result waits in the
//   done state until the output register takes it; a modulus below 2
//   goes straight to the done state
// throughput: one word at a time; the shared one-bit-per-cycle divide and
//   mod-add unit is the limit, so in_ready is low until the result is handed
//   to the output register
// reset: modulus returns to 256, no word in flight, out_valid low
// stall: a result waits in the output register while out_ready is low; a
//   new input word is taken meanwhile, and the next result waits inside
//   the core until the register is free
`default_nettype none

module modular_inverse_unit
    import miu_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [WIDTH-1:0] modulus,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] inverse,
    output logic                  has_inverse
);

    logic [WIDTH-1:0] modulus_reg;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] inverse_reg;
    logic             has_inverse_reg;
    miu_status_t      status;
    logic             start;
    logic             res_ack;
    logic [WIDTH-1:0] res_inverse;
    logic             res_has_inverse;

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= WIDTH'(MODULUS_RESET);
        else if (cfg_valid)
            modulus_reg <= modulus;
    end

    // input handshake
    assign in_ready = !status.busy;
    assign start    = in_valid && in_ready;

    // hand result to output register when it is free or being drained
    assign res_ack        = status.done && (!out_valid_reg || out_ready);
    assign out_valid_next = res_ack ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            inverse_reg     <= res_inverse;
            has_inverse_reg <= res_has_inverse;
        end
    end

    assign out_valid   = out_valid_reg;
    assign inverse     = inverse_reg;
    assign has_inverse = has_inverse_reg;

    // euclid sequencer and shared divide unit
    miu_core #(
        .WIDTH (WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .value           (value),
        .modulus         (modulus_reg),
        .res_ack         (res_ack),
        .status          (status),
        .res_inverse     (res_inverse),
        .res_has_inverse (res_has_inverse)
    );

    // checks
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !in_ready)
        else $error("core not busy after accepting a word");

    a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> status.busy)
        else $error("done reported while core idle");

    a_no_inverse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_inverse) |-> (inverse == '0))
        else $error("nonzero inverse without has_inverse");

    a_inverse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_inverse) |-> (inverse != '0))
        else $error("zero inverse flagged as valid");

endmodule

`default_nettype wire
